// ----- rtl/rfp_pkg.sv -----
// rfp_pkg: shared types and constants of the rs485 frame parser
// used by rfp_front, rfp_fifo, rfp_back and the top level
package rfp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int MEM_AW      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 * MAX_PAYLOAD;
    localparam int CRC_CNT_W   = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_CNT_W-1:0] CRC_BITS = CRC_CNT_W'(8);

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_CRC_ERR = 2'd2
    } frame_status_t;

    typedef struct packed {
        frame_status_t status;
        logic [7:0]    address;
        logic [7:0]    command;
        logic [7:0]    sequence_no;
        logic [7:0]    length;
        logic          bank;
    } frame_desc_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        data;
    } pay_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

    function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
        crc_bit_step = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    endfunction

endpackage

// ----- rtl/rfp_fifo.sv -----
// rfp_fifo: two-entry queue of frame descriptors between parser and emitter
// depends on rfp_pkg
module rfp_fifo import rfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  frame_desc_t push_desc,
    output logic        full,
    input  logic        pop,
    output frame_desc_t head,
    output logic        empty
);

    frame_desc_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- rtl/rfp_front.sv -----
// rfp_front: byte parser with bit-serial crc-16, payload write and frame descriptors
// depends on rfp_pkg
module rfp_front import rfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  preamble,
    output logic        push,
    output frame_desc_t push_desc,
    input  logic        fifo_full,
    input  bank_rel_t   release_bank,
    output pay_wr_t     pay_wr
);

    typedef enum logic [7:0] {
        PH_HUNT   = 8'b0000_0001,
        PH_ADDR   = 8'b0000_0010,
        PH_CMD    = 8'b0000_0100,
        PH_SEQ    = 8'b0000_1000,
        PH_LEN    = 8'b0001_0000,
        PH_DATA   = 8'b0010_0000,
        PH_CRC_LO = 8'b0100_0000,
        PH_CRC_HI = 8'b1000_0000
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [15:0]          crc_reg, crc_next;
    logic [CRC_CNT_W-1:0] crc_cnt_reg, crc_cnt_next;
    logic [7:0]           addr_reg, addr_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic [7:0]           seq_reg, seq_next;
    logic [7:0]           len_reg, len_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [7:0]           crc_lo_reg, crc_lo_next;
    logic                 bank_reg, bank_next;
    logic [1:0]           busy_reg, busy_next;
    logic                 accept;
    logic [15:0]          crc_fed;

    always_comb begin
        s_tready = (crc_cnt_reg == '0);
        case (phase_reg)
            PH_LEN, PH_CRC_HI: s_tready = s_tready && !fifo_full;
            PH_DATA:           s_tready = s_tready && !busy_reg[bank_reg];
            default:           s_tready = s_tready;
        endcase
    end

    assign accept  = s_tvalid && s_tready;
    // first bit step taken at the accepting edge
    assign crc_fed = crc_bit_step(crc_reg ^ {8'h00, rx_byte});

    always_comb begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        crc_cnt_next = crc_cnt_reg;
        addr_next    = addr_reg;
        cmd_next     = cmd_reg;
        seq_next     = seq_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        crc_lo_next  = crc_lo_reg;
        bank_next    = bank_reg;
        busy_next    = busy_reg;
        push         = 1'b0;
        push_desc.status      = ST_GOOD;
        push_desc.address     = addr_reg;
        push_desc.command     = cmd_reg;
        push_desc.sequence_no = seq_reg;
        push_desc.length      = len_reg;
        push_desc.bank        = bank_reg;
        pay_wr.en   = 1'b0;
        pay_wr.addr = {bank_reg, idx_reg[IDX_W-1:0]};
        pay_wr.data = rx_byte;

        if (release_bank.valid) begin
            busy_next[release_bank.bank] = 1'b0;
        end

        if (crc_cnt_reg != '0) begin
            crc_next     = crc_bit_step(crc_reg);
            crc_cnt_next = crc_cnt_reg - CRC_CNT_W'(1);
        end else if (accept) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == preamble) begin
                        crc_next     = crc_fed;
                        crc_cnt_next = CRC_BITS - CRC_CNT_W'(1);
                        phase_next   = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    addr_next    = rx_byte;
                    crc_next     = crc_fed;
                    crc_cnt_next = CRC_BITS - CRC_CNT_W'(1);
                    phase_next   = PH_CMD;
                end
                PH_CMD: begin
                    cmd_next     = rx_byte;
                    crc_next     = crc_fed;
                    crc_cnt_next = CRC_BITS - CRC_CNT_W'(1);
                    phase_next   = PH_SEQ;
                end
                PH_SEQ: begin
                    seq_next     = rx_byte;
                    crc_next     = crc_fed;
                    crc_cnt_next = CRC_BITS - CRC_CNT_W'(1);
                    phase_next   = PH_LEN;
                end
                PH_LEN: begin
                    len_next = rx_byte;
                    idx_next = '0;
                    if (rx_byte > 8'(MAX_PAYLOAD)) begin
                        push             = 1'b1;
                        push_desc.status = ST_BAD_LEN;
                        push_desc.length = rx_byte;
                        phase_next       = PH_HUNT;
                        crc_next         = CRC_INIT;
                    end else begin
                        crc_next     = crc_fed;
                        crc_cnt_next = CRC_BITS - CRC_CNT_W'(1);
                        phase_next   = (rx_byte == 8'h00) ? PH_CRC_LO : PH_DATA;
                    end
                end
                PH_DATA: begin
                    pay_wr.en    = 1'b1;
                    crc_next     = crc_fed;
                    crc_cnt_next = CRC_BITS - CRC_CNT_W'(1);
                    idx_next     = idx_reg + CNT_W'(1);
                    if ((8'(idx_reg) + 8'd1) >= len_reg) begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    crc_lo_next = rx_byte;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    push = 1'b1;
                    if ({rx_byte, crc_lo_reg} != crc_reg) begin
                        push_desc.status = ST_CRC_ERR;
                    end else if (len_reg != 8'h00) begin
                        busy_next[bank_reg] = 1'b1;
                        bank_next           = ~bank_reg;
                    end
                    phase_next = PH_HUNT;
                    crc_next   = CRC_INIT;
                    idx_next   = '0;
                end
                default: begin
                    phase_next = PH_HUNT;
                    crc_next   = CRC_INIT;
                    idx_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= CRC_INIT;
            crc_cnt_reg <= '0;
            addr_reg    <= '0;
            cmd_reg     <= '0;
            seq_reg     <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            crc_lo_reg  <= '0;
            bank_reg    <= 1'b0;
            busy_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            crc_cnt_reg <= crc_cnt_next;
            addr_reg    <= addr_next;
            cmd_reg     <= cmd_next;
            seq_reg     <= seq_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            crc_lo_reg  <= crc_lo_next;
            bank_reg    <= bank_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

// ----- rtl/rfp_back.sv -----
// rfp_back: result emitter with the two-bank payload memory
// depends on rfp_pkg
module rfp_back import rfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  pay_wr_t     pay_wr,
    input  frame_desc_t head,
    input  logic        empty,
    output logic        pop,
    output bank_rel_t   release_bank,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_SHOW = 3'b100
    } bstate_t;

    bstate_t          state_reg, state_next;
    frame_desc_t      cur_reg, cur_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             has_reg, has_next;
    logic             last_reg, last_next;
    logic [7:0]       pb_reg;
    logic             rd_en;
    logic             clr_pb;
    logic [7:0]       mem [MEM_DEPTH];

    assign m_tvalid = (state_reg == B_SHOW);
    assign m_tdata  = {pb_reg, cur_reg.length, cur_reg.sequence_no,
                       cur_reg.command, cur_reg.address};
    assign m_tuser  = {has_reg, cur_reg.status};
    assign m_tlast  = last_reg;

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        has_next   = has_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        clr_pb     = 1'b0;
        release_bank.valid = 1'b0;
        release_bank.bank  = cur_reg.bank;
        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    pop      = 1'b1;
                    cur_next = head;
                    idx_next = '0;
                    if (head.status != ST_GOOD || head.length == 8'h00) begin
                        has_next   = 1'b0;
                        last_next  = 1'b1;
                        clr_pb     = 1'b1;
                        state_next = B_SHOW;
                    end else begin
                        has_next   = 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            B_READ: begin
                rd_en      = 1'b1;
                last_next  = ((8'(idx_reg) + 8'd1) == cur_reg.length);
                state_next = B_SHOW;
            end
            B_SHOW: begin
                if (m_tready) begin
                    if (last_reg) begin
                        release_bank.valid = has_reg;
                        state_next         = B_IDLE;
                    end else begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
            has_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            has_reg   <= has_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (pay_wr.en) begin
            mem[pay_wr.addr] <= pay_wr.data;
        end
        if (rd_en) begin
            pb_reg <= mem[{cur_reg.bank, idx_reg[IDX_W-1:0]}];
        end else if (clr_pb) begin
            pb_reg <= '0;
        end
    end

endmodule

// ----- rtl/rs485_frame_parser_crc16.sv -----
// rs485_frame_parser_crc16: top level of the rs485 frame parser with crc-16 check
// depends on rfp_pkg, rfp_front, rfp_fifo and rfp_back
//
// Received bytes enter one word at a time on the s_ side. For a byte that feeds the
// crc (preamble, header and payload) the first bit step of the bit-serial crc-16
// update happens at the accepting edge and seven more follow in the parser, which
// takes no new byte meanwhile; ignored bytes, an oversized length byte and the
// two crc bytes take no bit steps. Finished frames go into a two-entry descriptor
// queue and the emitter sends them out on the m_ side: one word per payload byte
// (payload memory read, then show state), or a single status word for an empty,
// oversized or crc-failed frame. Payload is held in two banks so the next frame
// can be received while the last one drains; the parser stalls on a payload byte
// while both banks still hold frames not yet sent, and on a length byte or the
// last crc byte while the descriptor queue is full. No clearing pass after reset.
module rs485_frame_parser_crc16 import rfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // dest_address, command, sequence_res,
                                   // payload_length, payload_byte
    output logic [2:0]  m_tuser,   // status, has_payload
    output logic        m_tlast
);

    logic [7:0]  preamble_reg;
    logic        push;
    frame_desc_t push_desc;
    logic        fifo_full;
    logic        fifo_empty;
    logic        pop;
    frame_desc_t head;
    bank_rel_t   release_bank;
    pay_wr_t     pay_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg <= '0;
        end else if (cfg_we) begin
            preamble_reg <= cfg_wdata;
        end
    end

    rfp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .rx_byte      (s_tdata),
        .preamble     (preamble_reg),
        .push         (push),
        .push_desc    (push_desc),
        .fifo_full    (fifo_full),
        .release_bank (release_bank),
        .pay_wr       (pay_wr)
    );

    rfp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (fifo_full),
        .pop       (pop),
        .head      (head),
        .empty     (fifo_empty)
    );

    rfp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pay_wr       (pay_wr),
        .head         (head),
        .empty        (fifo_empty),
        .pop          (pop),
        .release_bank (release_bank),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

// ----- dv/rs485_frame_parser_crc16_tb.sv -----
// rs485_frame_parser_crc16_tb: self-checking bench for the rs485 frame parser with crc-16
// depends on rfp_pkg and rs485_frame_parser_crc16; drives bytes on s_, checks words on m_
// against a byte-level parser model, with a directed table followed by random frames
`timescale 1ns / 1ps

module rs485_frame_parser_crc16_tb;
    import rfp_pkg::*;

    localparam int LIMIT       = 400000;
    localparam int SETTLE      = 24;
    localparam int RAND_ITEMS  = 64;

    typedef enum logic [2:0] {
        P_HUNT, P_ADDR, P_CMD, P_SEQ, P_LEN, P_DATA, P_CRC_LO, P_CRC_HI
    } parse_ph_t;

    typedef enum logic [1:0] {K_RAW, K_CRC_LO, K_CRC_HI, K_CRC_HI_BAD} row_kind_t;

    typedef struct packed {
        frame_status_t status;
        logic [7:0]    addr;
        logic [7:0]    cmd;
        logic [7:0]    seq;
        logic [7:0]    len;
        logic          has;
        logic [7:0]    pb;
        logic          last;
    } word_t;

    typedef struct {
        row_kind_t  kind;
        logic [7:0] val;
        bit         typed;
        word_t      want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    rs485_frame_parser_crc16 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // parser model state
    parse_ph_t   ph = P_HUNT;
    logic [7:0]  sync_byte = 8'h00;
    logic [15:0] crc = CRC_INIT;
    logic [7:0]  hdr_addr = 8'h00;
    logic [7:0]  hdr_cmd = 8'h00;
    logic [7:0]  hdr_seq = 8'h00;
    logic [7:0]  hdr_len = 8'h00;
    logic [7:0]  crc_lo = 8'h00;
    int          pay_idx = 0;
    logic [7:0]  pay_buf [MAX_PAYLOAD];

    word_t step_words[$];
    word_t awaited_words[$];
    row_t  rows[$];

    bit calm = 1'b0;
    int errors = 0;
    int cycles = 0;
    int fed_items = 0;
    int words_seen = 0;
    int frames_good = 0;
    int frames_bad_len = 0;
    int frames_crc_err = 0;
    word_t got_w;
    word_t want_w;

    function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic word_t mk_word(frame_status_t st, logic [7:0] a, logic [7:0] c,
                                      logic [7:0] s, logic [7:0] l);
        word_t w;
        w = '0;
        w.status = st;
        w.addr = a;
        w.cmd = c;
        w.seq = s;
        w.len = l;
        w.last = 1'b1;
        return w;
    endfunction

    function automatic void emit_word(frame_status_t st, logic has, logic [7:0] pb,
                                      logic last);
        word_t w;
        w = mk_word(st, hdr_addr, hdr_cmd, hdr_seq, hdr_len);
        w.has = has;
        w.pb = pb;
        w.last = last;
        step_words.push_back(w);
    endfunction

    function automatic void rehunt();
        ph = P_HUNT;
        crc = CRC_INIT;
        pay_idx = 0;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        case (ph)
            P_HUNT: begin
                if (b == sync_byte) begin
                    crc = crc16_fold(CRC_INIT, b);
                    ph = P_ADDR;
                end
            end
            P_ADDR: begin
                hdr_addr = b;
                crc = crc16_fold(crc, b);
                ph = P_CMD;
            end
            P_CMD: begin
                hdr_cmd = b;
                crc = crc16_fold(crc, b);
                ph = P_SEQ;
            end
            P_SEQ: begin
                hdr_seq = b;
                crc = crc16_fold(crc, b);
                ph = P_LEN;
            end
            P_LEN: begin
                hdr_len = b;
                if (int'(b) > MAX_PAYLOAD) begin
                    emit_word(ST_BAD_LEN, 1'b0, 8'h00, 1'b1);
                    rehunt();
                end else begin
                    crc = crc16_fold(crc, b);
                    pay_idx = 0;
                    ph = (b == 8'h00) ? P_CRC_LO : P_DATA;
                end
            end
            P_DATA: begin
                pay_buf[pay_idx] = b;
                crc = crc16_fold(crc, b);
                pay_idx++;
                if (pay_idx >= int'(hdr_len))
                    ph = P_CRC_LO;
            end
            P_CRC_LO: begin
                crc_lo = b;
                ph = P_CRC_HI;
            end
            default: begin
                if ({b, crc_lo} != crc)
                    emit_word(ST_CRC_ERR, 1'b0, 8'h00, 1'b1);
                else if (hdr_len == 8'h00)
                    emit_word(ST_GOOD, 1'b0, 8'h00, 1'b1);
                else
                    for (int i = 0; i < int'(hdr_len); i++)
                        emit_word(ST_GOOD, 1'b1, pay_buf[i], i == int'(hdr_len) - 1);
                rehunt();
            end
        endcase
    endfunction

    function automatic void add_row(row_kind_t kind, logic [7:0] val);
        row_t r;
        r.kind = kind;
        r.val = val;
        r.typed = 1'b0;
        r.want = '0;
        rows.push_back(r);
    endfunction

    function automatic void add_typed(row_kind_t kind, logic [7:0] val, word_t want);
        row_t r;
        r.kind = kind;
        r.val = val;
        r.typed = 1'b1;
        r.want = want;
        rows.push_back(r);
    endfunction

    // one word on s_, with a random gap in front unless calm
    task automatic send_byte(input logic [7:0] b, input bit typed, input word_t want);
        if (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        if (ph != P_HUNT || b == sync_byte)
            fed_items++;
        step_words.delete();
        parse_rx_byte(b);
        if (typed)
            awaited_words.push_back(want);
        else
            foreach (step_words[i]) awaited_words.push_back(step_words[i]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        while (ph != P_HUNT) send_byte(8'($urandom_range(255)), 1'b0, '0);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sync_byte = v;
    endtask

    // mostly well-formed frames; some noise, truncation, oversize and bad crc
    task automatic send_frame();
        logic [7:0] b;
        logic [7:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
        int r;
        int cut;
        if ($urandom_range(99) < 10)
            repeat ($urandom_range(3, 1)) begin
                b = 8'($urandom_range(255));
                if (b == sync_byte) b ^= 8'h01;
                send_byte(b, 1'b0, '0);
            end
        send_byte(sync_byte, 1'b0, '0);
        repeat (3) send_byte(8'($urandom_range(255)), 1'b0, '0);
        r = $urandom_range(99);
        if (r < 55)      len = 8'($urandom_range(4));
        else if (r < 80) len = 8'($urandom_range(12, 5));
        else if (r < 88) len = 8'(MAX_PAYLOAD);
        else             len = 8'($urandom_range(255, MAX_PAYLOAD + 1));
        send_byte(len, 1'b0, '0);
        if (int'(len) > MAX_PAYLOAD)
            return;
        cut = (len != 0 && $urandom_range(99) < 6) ? int'($urandom_range(int'(len) - 1)) : -1;
        for (int i = 0; i < int'(len); i++) begin
            if (i == cut)
                return;
            send_byte(8'($urandom_range(255)), 1'b0, '0);
        end
        lo = crc[7:0];
        hi = crc[15:8];
        r = $urandom_range(99);
        if (r < 7)       lo ^= 8'($urandom_range(255, 1));
        else if (r < 14) hi ^= 8'($urandom_range(255, 1));
        send_byte(lo, 1'b0, '0);
        send_byte(hi, 1'b0, '0);
    endtask

    task automatic check_field(input string nm, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, nm, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 13);

    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d words still awaited", cycles,
                     awaited_words.size());
            $display("rs485_frame_parser_crc16_tb failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_w.addr = m_tdata[7:0];
            got_w.cmd = m_tdata[15:8];
            got_w.seq = m_tdata[23:16];
            got_w.len = m_tdata[31:24];
            got_w.pb = m_tdata[39:32];
            got_w.status = frame_status_t'(m_tuser[1:0]);
            got_w.has = m_tuser[2];
            got_w.last = m_tlast;
            if (awaited_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual tdata %h tuser %h last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want_w = awaited_words.pop_front();
                words_seen++;
                check_field("status", 8'(want_w.status), 8'(got_w.status));
                check_field("dest_address", want_w.addr, got_w.addr);
                check_field("command", want_w.cmd, got_w.cmd);
                check_field("sequence", want_w.seq, got_w.seq);
                check_field("payload_length", want_w.len, got_w.len);
                check_field("has_payload", 8'(want_w.has), 8'(got_w.has));
                check_field("payload_byte", want_w.pb, got_w.pb);
                check_field("last", 8'(want_w.last), 8'(got_w.last));
                if (want_w.last) begin
                    case (want_w.status)
                        ST_GOOD:    frames_good++;
                        ST_BAD_LEN: frames_bad_len++;
                        default:    frames_crc_err++;
                    endcase
                end
            end
        end
    end

    initial begin
        logic [7:0] b;
        logic [7:0] sync_plan [4];
        sync_plan[0] = 8'hFF;
        sync_plan[1] = 8'h00;
        sync_plan[2] = 8'h7E;
        sync_plan[3] = 8'($urandom_range(255));

        // reset preamble is zero: noise, oversize extremes, empty good frame, bad crc
        add_row(K_RAW, 8'h5A);
        add_row(K_RAW, 8'hFF);
        add_row(K_RAW, 8'h00);
        add_row(K_RAW, 8'hFF);
        add_row(K_RAW, 8'h00);
        add_row(K_RAW, 8'hFF);
        add_typed(K_RAW, 8'hFF, mk_word(ST_BAD_LEN, 8'hFF, 8'h00, 8'hFF, 8'hFF));
        add_row(K_RAW, 8'h00);
        add_row(K_RAW, 8'h01);
        add_row(K_RAW, 8'h02);
        add_row(K_RAW, 8'h03);
        add_typed(K_RAW, 8'h21, mk_word(ST_BAD_LEN, 8'h01, 8'h02, 8'h03, 8'h21));
        add_row(K_RAW, 8'h00);
        add_row(K_RAW, 8'h10);
        add_row(K_RAW, 8'h20);
        add_row(K_RAW, 8'h30);
        add_row(K_RAW, 8'h00);
        add_row(K_CRC_LO, 8'h00);
        add_typed(K_CRC_HI, 8'h00, mk_word(ST_GOOD, 8'h10, 8'h20, 8'h30, 8'h00));
        add_row(K_RAW, 8'h00);
        add_row(K_RAW, 8'hA5);
        add_row(K_RAW, 8'h5A);
        add_row(K_RAW, 8'hC3);
        add_row(K_RAW, 8'h00);
        add_row(K_CRC_LO, 8'h00);
        add_typed(K_CRC_HI_BAD, 8'h00, mk_word(ST_CRC_ERR, 8'hA5, 8'h5A, 8'hC3, 8'h00));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            case (rows[i].kind)
                K_CRC_LO:     b = crc[7:0];
                K_CRC_HI:     b = crc[15:8];
                K_CRC_HI_BAD: b = ~crc[15:8];
                default:      b = rows[i].val;
            endcase
            send_byte(b, rows[i].typed, rows[i].want);
        end

        fed_items = 0;
        for (int p = 0; p < 4; p++) begin
            write_sync(sync_plan[p]);
            calm = (p == 2);
            while (fed_items < RAND_ITEMS * (p + 1) / 4)
                send_frame();
        end
        calm = 1'b0;
        drain();

        $display("%0d random bytes after the directed table, %0d words checked",
                 fed_items, words_seen);
        $display("frames: %0d good, %0d oversized, %0d crc errors, over four preamble values",
                 frames_good, frames_bad_len, frames_crc_err);
        if (errors == 0)
            $display("rs485_frame_parser_crc16_tb passed");
        else
            $display("rs485_frame_parser_crc16_tb failed");
        $finish;
    end

endmodule
